>>> rtl/lmsbs_pkg.sv
// Package for the LED matrix scan and button sense core.
// Holds the matrix geometry, field widths, threshold reset values and code types.
// Depends on nothing; imported by the core, scan_result_checker and the testbench top.
package lmsbs_pkg;

	// Matrix geometry and frame length.
	localparam int ROWS            = 5;
	localparam int COLS            = 6;
	localparam int SENSE_LINES     = 4;
	localparam int TICKS_PER_FRAME = 33;

	localparam int LED_COUNT      = ROWS * COLS;
	localparam int PRECHARGE_TICK = LED_COUNT;
	localparam int CONVERT_TICK   = LED_COUNT + 1;

	// Widths of the word fields and the internal counters.
	localparam int ACTION_W = 2;
	localparam int ROW_W    = 3;
	localparam int COL_W    = 3;
	localparam int BITS_W   = 6;
	localparam int SAMPLE_W = 10;
	localparam int DRIVE_W  = 2;
	localparam int LED_W    = 5;
	localparam int LINE_W   = 2;
	localparam int MASK_W   = 4;
	localparam int TICK_W   = 6;
	localparam int CFG_IDX_W = 2;

	// Threshold reset values: eleven twelfths and seven eighths of full scale.
	localparam logic [SAMPLE_W-1:0] LINE_THR_RESET      = SAMPLE_W'(1023 * 11 / 12);
	localparam logic [SAMPLE_W-1:0] LINE_ZERO_THR_RESET = SAMPLE_W'(1023 * 7 / 8);

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK   = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_ROW    = 2'd2
	} action_t;

	typedef enum logic [DRIVE_W-1:0] {
		DRIVE_OFF       = 2'd0,
		DRIVE_LIT       = 2'd1,
		DRIVE_PRECHARGE = 2'd2,
		DRIVE_HOLD      = 2'd3
	} drive_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_THR      = 2'd0,
		CFG_LINE_ZERO_THR = 2'd1
	} cfg_index_t;

endpackage

>>> rtl/led_matrix_scan_button_sense_core.sv
// A word accepted at the input is held in the input register, then passes through the sequencer
// logic into the result register (input register, then result register), where its result word is offered.
// One word per cycle while out_ready is high, set by the single step of logic from the input
// register to the result register; a stalled result register holds the input register back.
// Reset (arst_n low, asynchronous) clears the tick, row and column counters, sense line,
// both frame buffers and both masks, and loads the threshold reset values.
// Configuration writes are taken in every cycle; no clearing pass is needed.
module led_matrix_scan_button_sense_core
	import lmsbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]  cfg_data,
	// Input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ACTION_W-1:0]  action,
	input  logic [ROW_W-1:0]     row_select,
	input  logic [BITS_W-1:0]    row_bits,
	input  logic [SAMPLE_W-1:0]  sample,
	// Result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DRIVE_W-1:0]   drive,
	output logic [LED_W-1:0]     led_index,
	output logic                 convert_start,
	output logic [LINE_W-1:0]    convert_channel,
	output logic                 convert_off,
	output logic [MASK_W-1:0]    buttons,
	output logic                 frame_done
);

	// Configuration registers
	logic [SAMPLE_W-1:0] line_thr_q;
	logic [SAMPLE_W-1:0] line_zero_thr_q;

	// Input register
	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [ROW_W-1:0]    row_select_s1;
	logic [BITS_W-1:0]   row_bits_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// Result register
	logic                valid_s2;
	logic [DRIVE_W-1:0]  drive_s2;
	logic [LED_W-1:0]    led_s2;
	logic                cstart_s2;
	logic [LINE_W-1:0]   cchan_s2;
	logic                coff_s2;
	logic [MASK_W-1:0]   buttons_s2;
	logic                done_s2;

	// Scan and sense state
	logic [TICK_W-1:0]   tick_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [LINE_W-1:0]   line_q;
	logic [MASK_W-1:0]   gather_q;
	logic [MASK_W-1:0]   pub_q;
	logic [BITS_W-1:0]   shadow_q [ROWS];
	logic [BITS_W-1:0]   shown_q  [ROWS];

	// Next values
	logic [TICK_W-1:0]   tick_d;
	logic [ROW_W-1:0]    row_d;
	logic [COL_W-1:0]    col_d;
	logic [LINE_W-1:0]   line_d;
	logic [MASK_W-1:0]   gather_d;
	logic [MASK_W-1:0]   pub_d;
	logic [BITS_W-1:0]   shadow_d [ROWS];
	logic [BITS_W-1:0]   shown_d  [ROWS];
	drive_t              drive_d;
	logic [LED_W-1:0]    led_d;
	logic                cstart_d;
	logic [LINE_W-1:0]   cchan_d;
	logic                coff_d;
	logic                done_d;

	logic [TICK_W:0]     tick_inc;
	logic [LINE_W:0]     line_inc;
	logic [SAMPLE_W-1:0] thr;
	logic                advance;

	// The word in the input register moves on when the result register is free or emptying.
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_thr_q      <= LINE_THR_RESET;
			line_zero_thr_q <= LINE_ZERO_THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LINE_THR:      line_thr_q      <= cfg_data;
				CFG_LINE_ZERO_THR: line_zero_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1     <= action;
			row_select_s1 <= row_select;
			row_bits_s1   <= row_bits;
			sample_s1     <= sample;
		end
	end

	// One step of the scan sequencer for the word in the input register.
	always_comb begin
		drive_d  = DRIVE_HOLD;
		led_d    = '0;
		cstart_d = 1'b0;
		cchan_d  = '0;
		coff_d   = 1'b0;
		done_d   = 1'b0;
		tick_d   = tick_q;
		row_d    = row_q;
		col_d    = col_q;
		line_d   = line_q;
		gather_d = gather_q;
		pub_d    = pub_q;
		shadow_d = shadow_q;
		shown_d  = shown_q;
		tick_inc = {1'b0, tick_q} + (TICK_W+1)'(1);
		line_inc = {1'b0, line_q} + (LINE_W+1)'(1);
		thr      = (line_q == '0) ? line_zero_thr_q : line_thr_q;

		case (action_s1)
			ACT_TICK: begin
				if (tick_q < TICK_W'(LED_COUNT)) begin
					// LED slot: light the LED if its bit in the shown frame is set.
					if (shown_q[row_q][col_q]) begin
						drive_d = DRIVE_LIT;
						led_d   = tick_q[LED_W-1:0];
					end else begin
						drive_d = DRIVE_OFF;
					end
					if (col_q == COL_W'(COLS - 1)) begin
						col_d = '0;
						if (row_q != ROW_W'(ROWS - 1)) begin
							row_d = row_q + ROW_W'(1);
						end
					end else begin
						col_d = col_q + COL_W'(1);
					end
				end else if (tick_q == TICK_W'(PRECHARGE_TICK)) begin
					drive_d = DRIVE_PRECHARGE;
				end else if (tick_q == TICK_W'(CONVERT_TICK)) begin
					gather_d = '0;
					line_d   = '0;
					cstart_d = 1'b1;
				end
				// Frame wrap: latch the new frame and publish the gathered mask.
				if (tick_inc >= (TICK_W+1)'(TICKS_PER_FRAME)) begin
					shown_d = shadow_q;
					pub_d   = gather_d;
					tick_d  = '0;
					row_d   = '0;
					col_d   = '0;
					done_d  = 1'b1;
				end else begin
					tick_d = tick_inc[TICK_W-1:0];
				end
			end
			ACT_SAMPLE: begin
				// A sample below the line's threshold marks the button as pressed.
				if (sample_s1 < thr) begin
					gather_d[line_q] = 1'b1;
				end
				if (line_inc < (LINE_W+1)'(SENSE_LINES)) begin
					line_d   = line_inc[LINE_W-1:0];
					cstart_d = 1'b1;
					cchan_d  = line_inc[LINE_W-1:0];
				end else begin
					coff_d  = 1'b1;
					drive_d = DRIVE_OFF;
				end
			end
			ACT_ROW: begin
				if (row_select_s1 < ROW_W'(ROWS)) begin
					shadow_d[row_select_s1] = row_bits_s1;
				end
			end
			default: ;
		endcase
	end

	// State registers, updated as each word moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			line_q   <= '0;
			gather_q <= '0;
			pub_q    <= '0;
			for (int i = 0; i < ROWS; i++) begin
				shadow_q[i] <= '0;
				shown_q[i]  <= '0;
			end
		end else if (advance) begin
			tick_q   <= tick_d;
			row_q    <= row_d;
			col_q    <= col_d;
			line_q   <= line_d;
			gather_q <= gather_d;
			pub_q    <= pub_d;
			shadow_q <= shadow_d;
			shown_q  <= shown_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2   <= drive_d;
			led_s2     <= led_d;
			cstart_s2  <= cstart_d;
			cchan_s2   <= cchan_d;
			coff_s2    <= coff_d;
			buttons_s2 <= pub_d;
			done_s2    <= done_d;
		end
	end

	assign out_valid       = valid_s2;
	assign drive           = drive_s2;
	assign led_index       = led_s2;
	assign convert_start   = cstart_s2;
	assign convert_channel = cchan_s2;
	assign convert_off     = coff_s2;
	assign buttons         = buttons_s2;
	assign frame_done      = done_s2;

endmodule

>>> bench/scan_result_checker.sv
// Checker for the LED matrix scan and button sense core: watches the register, input and result
// channels, predicts each result word and compares it with what the core returns.
// Depends on lmsbs_pkg for geometry, widths, threshold reset values and code types.
`timescale 1ns / 1ps

module scan_result_checker
	import lmsbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]  cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [ACTION_W-1:0]  action,
	input  logic [ROW_W-1:0]     row_select,
	input  logic [BITS_W-1:0]    row_bits,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [DRIVE_W-1:0]   drive,
	input  logic [LED_W-1:0]     led_index,
	input  logic                 convert_start,
	input  logic [LINE_W-1:0]    convert_channel,
	input  logic                 convert_off,
	input  logic [MASK_W-1:0]    buttons,
	input  logic                 frame_done,
	output int                   mismatches,
	output int                   outstanding,
	output int                   results_checked
);

	localparam int REPORT_CAP = 40;

	typedef struct packed {
		drive_t              drive;
		logic [LED_W-1:0]    led;
		logic                start;
		logic [LINE_W-1:0]   chan;
		logic                off;
		logic [MASK_W-1:0]   mask;
		logic                done;
	} scan_result_t;

	// Own copy of the scan state and the thresholds.
	logic [TICK_W-1:0]   frame_tick;
	logic [LINE_W-1:0]   sense_idx;
	logic [BITS_W-1:0]   shadow_frame [ROWS];
	logic [BITS_W-1:0]   shown_frame [ROWS];
	logic [MASK_W-1:0]   gather_mask;
	logic [MASK_W-1:0]   publish_mask;
	logic [SAMPLE_W-1:0] thr_line;
	logic [SAMPLE_W-1:0] thr_zero;

	scan_result_t pending_results [$];
	scan_result_t oldest;

	// Advances the scan state by one word and returns the result word it causes.
	function automatic scan_result_t next_scan_result(
		input logic [ACTION_W-1:0] act,
		input logic [ROW_W-1:0]    row,
		input logic [BITS_W-1:0]   bits,
		input logic [SAMPLE_W-1:0] smp
	);
		scan_result_t r;
		int t;
		int line;
		logic [SAMPLE_W-1:0] thr;
		r = '0;
		r.drive = DRIVE_HOLD;
		case (act)
			ACT_TICK: begin
				t = int'(frame_tick);
				if (t < LED_COUNT) begin
					if (shown_frame[ROW_W'(t / COLS)][COL_W'(t % COLS)]) begin
						r.drive = DRIVE_LIT;
						r.led = LED_W'(t);
					end else begin
						r.drive = DRIVE_OFF;
					end
				end else if (t == PRECHARGE_TICK) begin
					r.drive = DRIVE_PRECHARGE;
				end else if (t == CONVERT_TICK) begin
					gather_mask = '0;
					sense_idx = '0;
					r.start = 1'b1;
					r.chan = '0;
				end
				t++;
				// Wrap: latch the shadow frame and publish the gathered mask.
				if (t >= TICKS_PER_FRAME) begin
					shown_frame = shadow_frame;
					publish_mask = gather_mask;
					t = 0;
					r.done = 1'b1;
				end
				frame_tick = TICK_W'(t);
			end
			ACT_SAMPLE: begin
				line = int'(sense_idx);
				thr = (line == 0) ? thr_zero : thr_line;
				if (smp < thr)
					gather_mask[sense_idx] = 1'b1;
				if (line + 1 < SENSE_LINES) begin
					sense_idx = LINE_W'(line + 1);
					r.start = 1'b1;
					r.chan = sense_idx;
				end else begin
					r.off = 1'b1;
					r.drive = DRIVE_OFF;
				end
			end
			ACT_ROW: begin
				if (row < ROW_W'(ROWS))
					shadow_frame[row] = bits;
			end
			default: begin
			end
		endcase
		r.mask = publish_mask;
		return r;
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
		end
	endfunction

	// Results are compared before the new prediction is queued, so a word that turns up
	// with nothing waiting is always caught.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_tick = '0;
			sense_idx = '0;
			gather_mask = '0;
			publish_mask = '0;
			thr_line = LINE_THR_RESET;
			thr_zero = LINE_ZERO_THR_RESET;
			for (int i = 0; i < ROWS; i++) begin
				shadow_frame[i] = '0;
				shown_frame[i] = '0;
			end
			pending_results.delete();
			mismatches = 0;
			results_checked = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("result word arrived with no prediction waiting");
				end else begin
					oldest = pending_results.pop_front();
					check_field("drive", int'(oldest.drive), int'(drive));
					check_field("led_index", int'(oldest.led), int'(led_index));
					check_field("convert_start", int'(oldest.start), int'(convert_start));
					check_field("convert_channel", int'(oldest.chan), int'(convert_channel));
					check_field("convert_off", int'(oldest.off), int'(convert_off));
					check_field("buttons", int'(oldest.mask), int'(buttons));
					check_field("frame_done", int'(oldest.done), int'(frame_done));
					results_checked++;
				end
			end
			// Register writes; indexes past the two thresholds change nothing.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LINE_THR:      thr_line = cfg_data;
					CFG_LINE_ZERO_THR: thr_zero = cfg_data;
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				pending_results.push_back(next_scan_result(action, row_select, row_bits, sample));
			outstanding <= pending_results.size();
		end
	end

endmodule

>>> bench/tb_led_matrix_scan_button_sense_core.sv
// Top of the testbench for led_matrix_scan_button_sense_core: clock, reset, register writes,
// directed and frame-shaped random words, idling on both channels, and the verdict.
// Depends on lmsbs_pkg, the core itself and scan_result_checker.
`timescale 1ns / 1ps

module tb_led_matrix_scan_button_sense_core;
	import lmsbs_pkg::*;

	// Codes the package leaves unnamed but the ports can carry.
	localparam logic [ACTION_W-1:0]  ACT_SPARE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int PHASE_WORDS = 112;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SAMPLE_W-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [ACTION_W-1:0]  action = '0;
	logic [ROW_W-1:0]     row_select = '0;
	logic [BITS_W-1:0]    row_bits = '0;
	logic [SAMPLE_W-1:0]  sample = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DRIVE_W-1:0]   drive;
	logic [LED_W-1:0]     led_index;
	logic                 convert_start;
	logic [LINE_W-1:0]    convert_channel;
	logic                 convert_off;
	logic [MASK_W-1:0]    buttons;
	logic                 frame_done;

	int mismatches;
	int outstanding;
	int results_checked;

	int idle_pct = 0;
	int stall_pct = 0;
	int tick_pos = 0;
	int phase_words = 0;
	int words_sent = 0;
	int frames_run = 0;
	int settings_used = 1;
	logic [SAMPLE_W-1:0] thr_line_set = LINE_THR_RESET;
	logic [SAMPLE_W-1:0] thr_zero_set = LINE_ZERO_THR_RESET;

	led_matrix_scan_button_sense_core dut (.*);

	scan_result_checker checker_inst (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Receiver stalls at random, at the rate the current phase sets.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// Offers one word, after an optional gap, and returns at the edge that accepts it.
	task automatic send_word(
		input logic [ACTION_W-1:0] act,
		input logic [ROW_W-1:0]    row,
		input logic [BITS_W-1:0]   bits,
		input logic [SAMPLE_W-1:0] smp
	);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		row_select <= row;
		row_bits <= bits;
		sample <= smp;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		if (act != ACT_SPARE && !(act == ACT_ROW && row >= ROW_W'(ROWS)))
			phase_words++;
		if (act == ACT_TICK)
			tick_pos = (tick_pos + 1) % TICKS_PER_FRAME;
	endtask

	// Holds the sender off until every predicted word has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write of a series.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_thresholds(input logic [SAMPLE_W-1:0] thr_l, input logic [SAMPLE_W-1:0] thr_z);
		write_reg(CFG_LINE_THR, thr_l);
		write_reg(CFG_SPARE_A, SAMPLE_W'($urandom));
		write_reg(CFG_SPARE_B, SAMPLE_W'($urandom));
		write_reg(CFG_LINE_ZERO_THR, thr_z);
		cfg_valid <= 1'b0;
		thr_line_set = thr_l;
		thr_zero_set = thr_z;
		settings_used++;
		@(posedge clk);
	endtask

	// Samples cluster round the threshold of the line they are meant for.
	function automatic logic [SAMPLE_W-1:0] pick_sample(input int line);
		logic [SAMPLE_W-1:0] thr;
		int sel;
		thr = (line == 0) ? thr_zero_set : thr_line_set;
		sel = $urandom_range(99);
		if (sel < 25)
			return thr - SAMPLE_W'(1);
		else if (sel < 50)
			return thr;
		else if (sel < 60)
			return thr + SAMPLE_W'(1);
		else if (sel < 70)
			return '0;
		else if (sel < 80)
			return '1;
		return SAMPLE_W'($urandom);
	endfunction

	// One frame of ticks with row writes, noise and a burst of conversions after the
	// conversion tick; now and then the frame is cut short or overrun.
	task automatic run_frame();
		int n_ticks;
		int n_samples;
		n_ticks = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : TICKS_PER_FRAME;
		for (int k = 0; k < n_ticks; k++) begin
			if ($urandom_range(99) < 12)
				send_word(ACT_ROW,
					ROW_W'(($urandom_range(9) == 0) ? $urandom_range(ROWS, 7)
						: $urandom_range(ROWS - 1)),
					BITS_W'($urandom), SAMPLE_W'($urandom));
			if ($urandom_range(99) < 5)
				send_word(ACTION_W'($urandom), ROW_W'($urandom), BITS_W'($urandom),
					SAMPLE_W'($urandom));
			if ($urandom_range(99) < 3)
				drain();
			send_word(ACT_TICK, ROW_W'($urandom), BITS_W'($urandom), SAMPLE_W'($urandom));
			if (tick_pos == CONVERT_TICK + 1) begin
				n_samples = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : SENSE_LINES;
				for (int s = 0; s < n_samples; s++)
					send_word(ACT_SAMPLE, ROW_W'($urandom), BITS_W'($urandom),
						pick_sample((s > 3) ? 3 : s));
			end
		end
		frames_run++;
	endtask

	// Idling mixes per phase: none, sender only, receiver only, both.
	int phase_idle [4] = '{0, 52, 0, 33};
	int phase_stall [4] = '{0, 0, 52, 33};

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: row extremes, ignored rows and action, then a full run of
		// conversions at the reset thresholds past the last line, and three ticks.
		send_word(ACT_ROW, 3'd0, 6'h3F, SAMPLE_W'($urandom));
		send_word(ACT_ROW, 3'd4, 6'h3F, SAMPLE_W'($urandom));
		send_word(ACT_ROW, 3'd2, 6'h00, SAMPLE_W'($urandom));
		send_word(ACT_ROW, 3'd7, 6'h2A, SAMPLE_W'($urandom));
		send_word(ACT_ROW, 3'd5, 6'h15, SAMPLE_W'($urandom));
		send_word(ACT_SPARE, ROW_W'($urandom), BITS_W'($urandom), SAMPLE_W'($urandom));
		send_word(ACT_SAMPLE, ROW_W'($urandom), BITS_W'($urandom), LINE_ZERO_THR_RESET);
		send_word(ACT_SAMPLE, ROW_W'($urandom), BITS_W'($urandom),
			LINE_THR_RESET - SAMPLE_W'(1));
		send_word(ACT_SAMPLE, ROW_W'($urandom), BITS_W'($urandom), LINE_THR_RESET);
		send_word(ACT_SAMPLE, ROW_W'($urandom), BITS_W'($urandom), '0);
		send_word(ACT_SAMPLE, ROW_W'($urandom), BITS_W'($urandom), '1);
		send_word(ACT_SAMPLE, ROW_W'($urandom), BITS_W'($urandom), '0);
		send_word(ACT_TICK, 3'd0, 6'h00, '0);
		send_word(ACT_TICK, 3'd7, 6'h3F, '1);
		send_word(ACT_TICK, ROW_W'($urandom), BITS_W'($urandom), SAMPLE_W'($urandom));

		// Random phases, each at its own threshold setting, extremes first.
		for (int p = 0; p < 4; p++) begin
			drain();
			case (p)
				0: apply_thresholds('1, '0);
				1: apply_thresholds('0, '1);
				2: apply_thresholds(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
				default: apply_thresholds(LINE_THR_RESET, LINE_ZERO_THR_RESET);
			endcase
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			phase_words = 0;
			while (phase_words < PHASE_WORDS)
				run_frame();
		end

		drain();
		repeat (10) @(posedge clk);

		$display("Covered %0d input words in %0d frames, four idling mixes, %0d threshold settings.",
			words_sent, frames_run, settings_used);
		$display("%0d result words compared, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
